[rtl/core/gtfp_pkg.sv]
// ----------------------------------------------------------------------------
// gtfp_pkg: gain tuning frame parser shared definitions
// Frame byte codes, frame length and the gain select codes.
// ----------------------------------------------------------------------------
package gtfp_pkg;

  // frame byte codes
  localparam logic [7:0] START_BYTE = 8'h24;  // '$'
  localparam logic [7:0] LETTER_P   = 8'h70;  // 'p'
  localparam logic [7:0] LETTER_I   = 8'h69;  // 'i'
  localparam logic [7:0] LETTER_D   = 8'h64;  // 'd'
  localparam logic [7:0] MINUS_BYTE = 8'h2D;  // '-'

  // frame layout
  localparam int unsigned FRAME_LEN    = 8;
  localparam int unsigned STORED_BYTES = FRAME_LEN - 2;
  localparam int unsigned POS_W        = $clog2(FRAME_LEN);

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t LAST_POS = pos_t'(FRAME_LEN - 1);

  // gain select codes
  typedef logic [1:0] gain_sel_t;
  localparam gain_sel_t GAIN_NONE = 2'd0;
  localparam gain_sel_t GAIN_P    = 2'd1;
  localparam gain_sel_t GAIN_I    = 2'd2;
  localparam gain_sel_t GAIN_D    = 2'd3;

endpackage

[rtl/core/gain_tuning_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// gain_tuning_frame_parser_top: 8-byte gain tuning frame parser
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one received serial
//   byte per item. Output channel (out_valid, out_stall, frame_end,
//   checksum_ok, gain_select, gain_bits) gives one result item per byte.
//   Frames are '$', command letter, sign byte, four little-endian float
//   bytes and a modulo-256 checksum of the first seven bytes. Bytes other
//   than '$' while hunting produce an all-zero result.
//   The result of a byte is registered and shown in the cycle after it is
//   taken. Throughput: one byte per cycle unless out_stall holds a result;
//   frame state is registered, the result sits in a single output register.
//   Stall: while out_stall holds a waiting result, in_stall goes high;
//   a new byte is taken in the same cycle the waiting result is taken.
//   Reset (rst, synchronous): byte count and running sum go to zero
//   (hunting) and the output register empties; stored frame bytes keep
//   their contents and are always rewritten before use.
// ----------------------------------------------------------------------------
module gain_tuning_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_end,
  output logic        checksum_ok,
  output logic [1:0]  gain_select,
  output logic [31:0] gain_bits
);

  // frame state
  gtfp_pkg::pos_t byte_count;
  gtfp_pkg::pos_t byte_count_next;
  logic [7:0]     running_sum;
  logic [7:0]     running_sum_next;
  logic [7:0]     frame_bytes [0:gtfp_pkg::STORED_BYTES-1];

  logic                accept;
  logic                drop;
  logic                last;
  logic                store;
  gtfp_pkg::pos_t      store_idx;
  logic                sum_match;
  gtfp_pkg::gain_sel_t sel;
  logic [31:0]         bits;
  logic                res_end;
  logic                res_ok;
  gtfp_pkg::gain_sel_t res_sel;
  logic [31:0]         res_bits;

  // handshake: take a byte when the output register is free or emptying
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // position decode
  assign drop      = (byte_count == '0) && (rx_byte != gtfp_pkg::START_BYTE);
  assign last      = (byte_count == gtfp_pkg::LAST_POS);
  assign store     = (byte_count != '0) && !last;
  assign store_idx = byte_count - gtfp_pkg::pos_t'(1);

  // frame state next values
  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    if (accept && !drop) begin
      if (last) begin
        byte_count_next  = '0;
        running_sum_next = '0;
      end else begin
        byte_count_next  = byte_count + gtfp_pkg::pos_t'(1);
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // letter, sign and payload bytes
  always_ff @(posedge clk) begin
    if (accept && store) begin
      frame_bytes[store_idx] <= rx_byte;
    end
  end

  // command decode
  always_comb begin
    case (frame_bytes[0])
      gtfp_pkg::LETTER_P: sel = gtfp_pkg::GAIN_P;
      gtfp_pkg::LETTER_I: sel = gtfp_pkg::GAIN_I;
      gtfp_pkg::LETTER_D: sel = gtfp_pkg::GAIN_D;
      default:            sel = gtfp_pkg::GAIN_NONE;
    endcase
  end

  // float pattern with optional sign flip
  always_comb begin
    bits = {frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2]};
    if (frame_bytes[1] == gtfp_pkg::MINUS_BYTE) begin
      bits[31] = ~bits[31];
    end
  end

  // result of this byte
  assign sum_match = (running_sum == rx_byte);
  assign res_end   = last;
  assign res_ok    = last && sum_match;
  assign res_sel   = res_ok ? sel : gtfp_pkg::GAIN_NONE;
  assign res_bits  = (res_sel != gtfp_pkg::GAIN_NONE) ? bits : 32'd0;

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_end   <= res_end;
      checksum_ok <= res_ok;
      gain_select <= res_sel;
      gain_bits   <= res_bits;
    end
  end

`ifndef SYNTHESIS
  // a good checksum is only reported on a frame end
  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> frame_end)
    else $error("checksum_ok without frame_end");

  // a gain is only selected by a good frame
  a_sel_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (gain_select != gtfp_pkg::GAIN_NONE) |-> checksum_ok)
    else $error("gain_select set without checksum_ok");

  // a start byte while hunting opens a frame
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    accept && (byte_count == '0) && (rx_byte == gtfp_pkg::START_BYTE)
    |=> byte_count == gtfp_pkg::pos_t'(1))
    else $error("start byte did not open a frame");

  // the checksum byte always returns to hunting
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> (byte_count == '0) && (running_sum == '0))
    else $error("frame state not cleared after checksum byte");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free output register");
`endif

endmodule
